[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ffba_pkg.sv]
// Package: types, constants and codes of the first-fit block allocator
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam longint unsigned HEAP_BYTES_DEF = 64'd16777216;
    localparam int unsigned HEADER_BYTES_DEF = 32;
    localparam logic [31:0] MAX_REQUEST_RST  = 32'd100000000;

    // Width of a cell index carried by the query, enough for the largest table
    localparam int unsigned IDX_BITS = 10;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_ZALLOC = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_RESIZE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SIZE = 2'd1,
        ST_FULL = 2'd2,
        ST_ADDR = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] request_size;
        logic [31:0] element_count;
        logic [31:0] buffer_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
        logic [6:0]  free_block_count;
        logic [31:0] free_byte_count;
        logic [6:0]  allocated_block_count;
        logic [31:0] allocated_byte_count;
        logic [11:0] header_byte_count;
    } t_out_item;

    // Query that travels along the cell chain
    typedef struct packed {
        logic                valid;
        logic                fit_mode;   // 1: first free block of size >= req; 0: address match
        logic [32:0]         req;
        logic [31:0]         addr;
        logic                found;
        logic                hit_free;
        logic [IDX_BITS-1:0] hit_idx;
        logic [31:0]         hit_start;
        logic [31:0]         hit_size;
    } t_query;

endpackage

[rtl/core/ffba_cell.sv]
// One table entry of the allocator chain with its compare stage
`timescale 1ns / 1ps
module ffba_cell #(
    parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int unsigned IDX          = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_use,
    input  logic               i_write_new,
    input  logic               i_set_free,
    input  logic               i_clr_free,
    input  logic [31:0]        i_new_start,
    input  logic [31:0]        i_new_size,
    input  ffba_pkg::t_query   i_q,
    output ffba_pkg::t_query   o_q
);
    import ffba_pkg::*;

    logic [31:0] r_start;
    logic [31:0] r_size;
    logic        r_free;
    t_query      r_q;
    t_query      n_q;
    logic [32:0] buf_addr;
    logic        hit;

    assign buf_addr = {1'b0, r_start} + 33'(HEADER_BYTES);

    // Match the passing query against this entry
    always_comb begin
        n_q = i_q;
        if (i_q.fit_mode) begin
            hit = i_in_use && r_free && ({1'b0, r_size} >= i_q.req);
        end else begin
            hit = i_in_use && (buf_addr == {1'b0, i_q.addr});
        end
        if (i_q.valid && !i_q.found && hit) begin
            n_q.found     = 1'b1;
            n_q.hit_free  = r_free;
            n_q.hit_idx   = IDX_BITS'(IDX);
            n_q.hit_start = r_start;
            n_q.hit_size  = r_size;
        end
    end

    // Hold the entry, apply updates
    always_ff @(posedge i_clk) begin
        if (i_write_new) begin
            r_start <= i_new_start;
            r_size  <= i_new_size;
            r_free  <= 1'b0;
        end else if (i_set_free) begin
            r_free <= 1'b1;
        end else if (i_clr_free) begin
            r_free <= 1'b0;
        end
    end

    // Advance the query to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

[rtl/core/first_fit_block_allocator.sv]
// Top level: command control, statistics and the chain of table cells
//
// First-fit allocator without splitting, keeping MAX_BLOCKS entries in a chain of cells.
// Issue a command by raising start while busy is low; one result follows, shown for one
// cycle with o_done, and cannot be stalled. Every command sends a query down the cell
// chain, one cell per cycle; busy falls in the same cycle that o_done rises, so a new
// item is taken only once the last one is through. Zeroed allocate first passes
// through S_MUL for its 32 x 32 multiply. A resize that must move its block runs a
// second, allocating pass.
// The max_request register is written through i_cfg_valid / o_cfg_ready while idle.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
    parameter int unsigned    MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter longint unsigned HEAP_BYTES  = ffba_pkg::HEAP_BYTES_DEF,
    parameter int unsigned    HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ffba_pkg::t_in_item  i_item,
    output logic                o_done,
    output ffba_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);
    import ffba_pkg::*;

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    t_state        r_state, n_state;
    logic [31:0]   r_max_req;
    t_in_item      r_in;
    logic [63:0]   r_prod;
    logic [32:0]   r_req;
    logic [CW-1:0] r_count;
    logic [31:0]   r_top;
    logic [CW-1:0] r_free_blk;
    logic [31:0]   r_free_bytes;
    logic [31:0]   r_used_bytes;
    logic [IW-1:0] r_tick;
    logic          r_phase2;    // resize: allocation pass after the address pass
    logic [IW-1:0] r_old_idx;
    logic [31:0]   r_old_size;
    t_query        r_res;
    t_status       r_status;
    logic [31:0]   r_addr;
    logic          r_done;

    t_query        q_chain [MAX_BLOCKS+1];
    t_query        q_launch;
    logic [32:0]   chk_req;
    logic [63:0]   append_end;
    logic [IW-1:0] hit_idx;
    logic [31:0]   rel_size;
    logic          size_bad;
    logic          heap_full;
    t_status       d_status;
    logic [31:0]   d_addr;
    logic          d_move;
    logic          d_reuse;
    logic          d_append;
    logic          d_release;
    logic [IW-1:0] d_rel_idx;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    // Build the chain
    assign q_chain[0] = q_launch;
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell #(.HEADER_BYTES(HEADER_BYTES), .IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_in_use   (CW'(g) < r_count),
            .i_write_new(d_append && (CW'(g) == r_count)),
            .i_set_free (d_release && (d_rel_idx == IW'(g))),
            .i_clr_free (d_reuse && (hit_idx == IW'(g))),
            .i_new_start(r_top),
            .i_new_size (r_req[31:0]),
            .i_q        (q_chain[g]),
            .o_q        (q_chain[g+1])
        );
    end

    assign hit_idx  = IW'(r_res.hit_idx);
    assign rel_size = r_phase2 ? r_old_size : r_res.hit_size;

    // Request launched into the chain: zeroed allocate uses the clamped product
    assign chk_req = (t_cmd'(r_in.command) == CMD_ZALLOC)
                     ? ((r_prod > {32'd0, r_max_req}) ? 33'h1_0000_0000
                                                      : {1'b0, r_prod[31:0]})
                     : r_req;

    assign append_end = {32'd0, r_top} + 64'(HEADER_BYTES) + {31'd0, r_req};
    assign heap_full  = (r_count == CW'(MAX_BLOCKS)) || (append_end > HEAP_BYTES);
    assign size_bad   = (r_req == '0) || (r_req > {1'b0, r_max_req})
                        || ((t_cmd'(r_in.command) == CMD_ZALLOC)
                            && ((r_in.request_size == '0) || (r_in.request_size > r_max_req)));

    // Next state and query launch of the sequencer
    always_comb begin
        n_state  = r_state;
        q_launch = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = (t_cmd'(i_item.command) == CMD_ZALLOC) ? S_MUL : S_CHECK;
            end
            S_MUL:    n_state = S_CHECK;
            S_CHECK: begin
                n_state           = S_SCAN;
                q_launch.valid    = 1'b1;
                q_launch.fit_mode = (t_cmd'(r_in.command) == CMD_ALLOC)
                                    || (t_cmd'(r_in.command) == CMD_ZALLOC);
                q_launch.req      = chk_req;
                q_launch.addr     = r_in.buffer_address;
            end
            S_SCAN: begin
                if (r_tick == IW'(MAX_BLOCKS - 1)) n_state = S_DECIDE;
            end
            S_DECIDE: n_state = d_move ? S_CHECK : S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Decide the outcome of a finished pass and the table updates it needs
    always_comb begin
        d_status  = ST_OK;
        d_addr    = '0;
        d_move    = 1'b0;
        d_reuse   = 1'b0;
        d_append  = 1'b0;
        d_release = 1'b0;
        d_rel_idx = hit_idx;
        if (r_state == S_DECIDE) begin
            unique case (t_cmd'(r_in.command))
                CMD_FREE: begin
                    if (!r_res.found || r_res.hit_free) begin
                        d_status = ST_ADDR;
                    end else begin
                        d_addr    = r_in.buffer_address;
                        d_release = 1'b1;
                    end
                end
                CMD_RESIZE: begin
                    if (!r_res.found || r_res.hit_free) begin
                        d_status = ST_ADDR;
                    end else if ({1'b0, r_res.hit_size} >= r_req) begin
                        d_addr = r_in.buffer_address;
                    end else begin
                        d_move = 1'b1;
                    end
                end
                CMD_ALLOC, CMD_ZALLOC: begin
                    if (size_bad) begin
                        d_status = ST_SIZE;
                    end else if (r_res.found) begin
                        d_reuse = 1'b1;
                        d_addr  = r_res.hit_start + 32'(HEADER_BYTES);
                    end else if (heap_full) begin
                        d_status = ST_FULL;
                    end else begin
                        d_append = 1'b1;
                        d_addr   = r_top + 32'(HEADER_BYTES);
                    end
                    // Release the old block of a moved resize once the new one is held
                    if (r_phase2 && (d_reuse || d_append)) begin
                        d_release = 1'b1;
                        d_rel_idx = r_old_idx;
                    end
                end
            endcase
        end
    end

    // Control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_req    <= MAX_REQUEST_RST;
            r_in         <= '0;
            r_prod       <= '0;
            r_req        <= '0;
            r_count      <= '0;
            r_top        <= '0;
            r_free_blk   <= '0;
            r_free_bytes <= '0;
            r_used_bytes <= '0;
            r_tick       <= '0;
            r_phase2     <= 1'b0;
            r_old_idx    <= '0;
            r_old_size   <= '0;
            r_res        <= '0;
            r_status     <= ST_OK;
            r_addr       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_max_req <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in     <= i_item;
                        r_req    <= {1'b0, i_item.request_size};
                        r_phase2 <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_prod <= 64'(r_in.element_count) * 64'(r_in.request_size);
                end
                S_CHECK: begin
                    r_req  <= chk_req;
                    r_tick <= '0;
                end
                S_SCAN: begin
                    r_tick <= r_tick + IW'(1);
                    // Catch the query as it leaves the last cell
                    if (r_tick == IW'(MAX_BLOCKS - 1)) r_res <= q_chain[MAX_BLOCKS];
                end
                S_DECIDE: begin
                    if (d_move) begin
                        r_phase2     <= 1'b1;
                        r_old_idx    <= hit_idx;
                        r_old_size   <= r_res.hit_size;
                        r_in.command <= CMD_ALLOC;
                    end else begin
                        r_status     <= d_status;
                        r_addr       <= d_addr;
                        r_free_blk   <= r_free_blk - (d_reuse ? CW'(1) : CW'(0))
                                        + (d_release ? CW'(1) : CW'(0));
                        r_free_bytes <= r_free_bytes - (d_reuse ? r_res.hit_size : 32'd0)
                                        + (d_release ? rel_size : 32'd0);
                        if (d_append) begin
                            r_top        <= append_end[31:0];
                            r_count      <= r_count + CW'(1);
                            r_used_bytes <= r_used_bytes + r_req[31:0];
                        end
                    end
                end
                S_DONE: r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    // Result
    assign o_done = r_done;
    always_comb begin
        o_item.status                = r_status;
        o_item.result_address        = r_addr;
        o_item.free_block_count      = 7'(r_free_blk);
        o_item.free_byte_count       = r_free_bytes;
        o_item.allocated_block_count = 7'(r_count);
        o_item.allocated_byte_count  = r_used_bytes;
        o_item.header_byte_count     = 12'(32'(r_count) * HEADER_BYTES);
    end
endmodule

[rtl/core/ffba_checker.sv]
// Port checker for the first-fit block allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffba_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input ffba_pkg::t_out_item o_item
);
    import ffba_pkg::*;

    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "accepted item did not raise busy")
    `CHK_SAME(a_done_busy, i_clk, i_rst_n, o_done, !$past(busy) == 1'b0, "result without a command")
    `CHK_SAME(a_err_addr, i_clk, i_rst_n, o_done && o_item.status != ST_OK, o_item.result_address == '0, "error result carries an address")
    `CHK_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe longer than one cycle")
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_done (o_done),
    .o_item (o_item)
);

[dv/first_fit_block_allocator_tb.sv]
// Self-checking testbench for the first-fit block allocator
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int unsigned NBLK    = MAX_BLOCKS_DEF;
    localparam int unsigned HDR     = HEADER_BYTES_DEF;
    localparam int unsigned LATENCY = 2 * NBLK + 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_done;
    t_out_item   o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    first_fit_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy), .i_item(i_item),
        .o_done(o_done), .o_item(o_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Clock: 2 ns period
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Shadow heap table and statistics
    logic [31:0] blk_start [NBLK];
    logic [31:0] blk_size  [NBLK];
    bit          blk_free  [NBLK];
    int unsigned n_blocks;
    logic [31:0] top;
    logic [31:0] free_blocks;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
    logic [31:0] max_req;

    t_out_item   pending_results[$];
    int          fail_count;
    bit          gaps_on;

    // First fit without splitting, else append at the heap top
    function automatic t_status grab_block(input logic [63:0] req, output logic [31:0] addr);
        logic [63:0] heap_end;
        addr = '0;
        if (req == 0 || req > {32'd0, max_req}) return ST_SIZE;
        for (int i = 0; i < n_blocks; i++) begin
            if (blk_free[i] && {32'd0, blk_size[i]} >= req) begin
                blk_free[i] = 1'b0;
                free_blocks = free_blocks - 1;
                free_bytes  = free_bytes - blk_size[i];
                addr = blk_start[i] + HDR;
                return ST_OK;
            end
        end
        if (n_blocks >= NBLK) return ST_FULL;
        heap_end = {32'd0, top} + HDR + req;
        if (heap_end > HEAP_BYTES_DEF) return ST_FULL;
        blk_start[n_blocks] = top;
        blk_size[n_blocks]  = req[31:0];
        blk_free[n_blocks]  = 1'b0;
        n_blocks++;
        used_bytes = used_bytes + req[31:0];
        addr = top + HDR;
        top  = heap_end[31:0];
        return ST_OK;
    endfunction

    // Index of the live block owning a user address, or -1
    function automatic int find_live(input logic [31:0] addr);
        for (int i = 0; i < n_blocks; i++)
            if ({32'd0, blk_start[i]} + HDR == {32'd0, addr})
                return blk_free[i] ? -1 : i;
        return -1;
    endfunction

    function automatic void mark_free(input int idx);
        blk_free[idx] = 1'b1;
        free_blocks = free_blocks + 1;
        free_bytes  = free_bytes + blk_size[idx];
    endfunction

    function automatic t_out_item predict_heap(input t_in_item it);
        t_out_item   r;
        t_status     st;
        logic [31:0] addr;
        int          idx;
        logic [63:0] nbytes;
        st = ST_OK;
        addr = '0;
        case (t_cmd'(it.command))
            CMD_ALLOC: st = grab_block({32'd0, it.request_size}, addr);
            CMD_ZALLOC: begin
                if (it.request_size == 0 || it.request_size > max_req) begin
                    st = ST_SIZE;
                end else begin
                    nbytes = {32'd0, it.element_count} * {32'd0, it.request_size};
                    st = grab_block(nbytes, addr);
                end
            end
            CMD_FREE: begin
                idx = find_live(it.buffer_address);
                if (idx < 0) begin
                    st = ST_ADDR;
                end else begin
                    mark_free(idx);
                    addr = it.buffer_address;
                end
            end
            default: begin
                idx = find_live(it.buffer_address);
                if (idx < 0) begin
                    st = ST_ADDR;
                end else if (blk_size[idx] >= it.request_size) begin
                    addr = it.buffer_address;
                end else begin
                    st = grab_block({32'd0, it.request_size}, addr);
                    if (st == ST_OK) mark_free(idx);
                end
            end
        endcase
        if (st != ST_OK) addr = '0;
        r.status                = st;
        r.result_address        = addr;
        r.free_block_count      = free_blocks[6:0];
        r.free_byte_count       = free_bytes;
        r.allocated_block_count = n_blocks[6:0];
        r.allocated_byte_count  = used_bytes;
        r.header_byte_count     = 12'(n_blocks * HDR);
        return r;
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("result with no expectation waiting");
            end else begin
                want = pending_results.pop_front();
                if (o_item.status !== want.status) begin
                    fail_count++;
                    $error("status exp %0d got %0d", want.status, o_item.status);
                end
                if (o_item.result_address !== want.result_address) begin
                    fail_count++;
                    $error("result_address exp %h got %h",
                           want.result_address, o_item.result_address);
                end
                if (o_item.free_block_count !== want.free_block_count) begin
                    fail_count++;
                    $error("free_block_count exp %0d got %0d",
                           want.free_block_count, o_item.free_block_count);
                end
                if (o_item.free_byte_count !== want.free_byte_count) begin
                    fail_count++;
                    $error("free_byte_count exp %0d got %0d",
                           want.free_byte_count, o_item.free_byte_count);
                end
                if (o_item.allocated_block_count !== want.allocated_block_count) begin
                    fail_count++;
                    $error("allocated_block_count exp %0d got %0d",
                           want.allocated_block_count, o_item.allocated_block_count);
                end
                if (o_item.allocated_byte_count !== want.allocated_byte_count) begin
                    fail_count++;
                    $error("allocated_byte_count exp %0d got %0d",
                           want.allocated_byte_count, o_item.allocated_byte_count);
                end
                if (o_item.header_byte_count !== want.header_byte_count) begin
                    fail_count++;
                    $error("header_byte_count exp %0d got %0d",
                           want.header_byte_count, o_item.header_byte_count);
                end
            end
        end
    end

    // Hold start until the item is taken, then predict it
    task automatic send_item(input t_cmd cmd, input logic [31:0] rsize,
                             input logic [31:0] cnt, input logic [31:0] baddr);
        bit taken;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item.command        = cmd;
        i_item.request_size   = rsize;
        i_item.element_count  = cnt;
        i_item.buffer_address = baddr;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        pending_results.push_back(predict_heap(i_item));
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (pending_results.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        if (pending_results.size() != 0) begin
            fail_count++;
            $error("results still outstanding: %0d", pending_results.size());
        end
    endtask

    // Write max_request while idle
    task automatic write_max_request(input logic [31:0] value);
        @(negedge i_clk);
        start = 1'b0;
        wait_drained();
        repeat (LATENCY) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_req = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_address();
        int sel;
        sel = $urandom_range(0, 9);
        if (n_blocks == 0 || sel == 0) return $urandom();
        if (sel == 1) return blk_start[$urandom_range(0, n_blocks - 1)] + $urandom_range(0, 63);
        return blk_start[$urandom_range(0, n_blocks - 1)] + HDR;
    endfunction

    function automatic logic [31:0] pick_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return $urandom();
        if (sel == 1) return 0;
        if (sel == 2) return max_req + $urandom_range(0, 1);
        return $urandom_range(1, 4096);
    endfunction

    task automatic test_directed();
        send_item(CMD_ALLOC, 0, 0, 0);
        send_item(CMD_ALLOC, max_req + 1, 0, 0);
        send_item(CMD_ALLOC, max_req, 0, 0);          // past the heap end
        send_item(CMD_ALLOC, 1, 0, 0);
        send_item(CMD_ALLOC, 100, 0, 0);
        send_item(CMD_ZALLOC, 0, 5, 0);
        send_item(CMD_ZALLOC, 4, 0, 0);
        send_item(CMD_ZALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(CMD_ZALLOC, max_req, 32'hFFFF_FFFF, 0);
        send_item(CMD_ZALLOC, 4, 3, 0);
        send_item(CMD_FREE, 0, 0, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 0, 0, HDR + 1);
        send_item(CMD_FREE, 0, 0, HDR);
        send_item(CMD_FREE, 0, 0, HDR);                // already free
        send_item(CMD_ALLOC, 1, 0, 0);                  // reuses the freed block
        send_item(CMD_RESIZE, 0, 0, HDR);               // shrink to zero in place
        send_item(CMD_RESIZE, 1, 0, HDR);
        send_item(CMD_RESIZE, 64, 0, HDR);              // must move
        send_item(CMD_RESIZE, max_req + 1, 0, 2 * HDR + 1); // move fails
        send_item(CMD_RESIZE, 8, 0, 32'hDEAD_BEEF);
        send_item(CMD_FREE, 0, 0, HDR);
        send_item(CMD_RESIZE, 8, 0, HDR);               // resize of a free block
    endtask

    task automatic test_config_extremes();
        write_max_request(32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, 0, 0);
        send_item(CMD_ALLOC, 32'd16777216, 0, 0);
        send_item(CMD_ZALLOC, 32'h0001_0000, 32'h0001_0000, 0);
        write_max_request(32'd1);
        send_item(CMD_ALLOC, 1, 0, 0);
        send_item(CMD_ALLOC, 2, 0, 0);
        send_item(CMD_ZALLOC, 1, 1, 0);
        send_item(CMD_ZALLOC, 1, 2, 0);
        write_max_request(32'd3000);
    endtask

    task automatic test_random(input int n_items);
        t_cmd        cmd;
        logic [31:0] cnt;
        for (int k = 0; k < n_items; k++) begin
            cmd = t_cmd'($urandom_range(0, 3));
            cnt = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 16);
            send_item(cmd, pick_size(), cnt, pick_address());
        end
    endtask

    task automatic test_idle_pause();
        @(negedge i_clk);
        start = 1'b0;
        wait_drained();
    endtask

    // Limit on the whole run
    initial begin
        #3000000;
        $display("first_fit_block_allocator_tb NOT OK");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        fail_count  = 0;
        gaps_on     = 1'b1;
        n_blocks    = 0;
        top         = '0;
        free_blocks = '0;
        free_bytes  = '0;
        used_bytes  = '0;
        max_req     = MAX_REQUEST_RST;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_random(500);
        test_idle_pause();
        test_random(300);
        write_max_request(MAX_REQUEST_RST);
        test_random(400);
        write_max_request(32'd64);
        test_random(200);
        gaps_on = 1'b0;
        test_random(220);

        @(negedge i_clk);
        start = 1'b0;
        wait_drained();
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("first_fit_block_allocator_tb OK");
        end else begin
            $display("first_fit_block_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
